// File: sv/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants of the environmental sensor compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

  typedef enum logic [2:0] {
    RegTempCoeffs     = 3'd0,
    RegPressCoeffsLow = 3'd1,
    RegPressCoeffsHi  = 3'd2,
    RegMixedCoeffs    = 3'd3,
    RegHumCoeffs      = 3'd4
  } esc_reg_e;

  // Unpacked calibration words
  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
    logic        [7:0]  h1;
    logic signed [15:0] h2;
    logic        [7:0]  h3;
    logic signed [11:0] h4;
    logic signed [11:0] h5;
    logic signed [7:0]  h6;
  } esc_coef_t;

  localparam logic signed [32:0] TempOffset   = 33'sd128000;
  localparam logic        [20:0] PressFull    = 21'd1048576;
  localparam logic signed [12:0] PressScale   = 13'sd3125;
  localparam logic signed [31:0] HumTempOfs   = 32'sd76800;
  localparam logic signed [31:0] HumRound     = 32'sd16384;
  localparam logic signed [31:0] HumBias      = 32'sd2097152;
  localparam logic signed [31:0] HumRoundY    = 32'sd8192;
  localparam logic signed [31:0] HumHalf      = 32'sd32768;
  localparam logic signed [31:0] HumMax       = 32'sd419430400;

endpackage

`default_nettype wire

// File: sv/env_sensor_compensation_top.sv
// ----------------------------------------------------------------------------
// env_sensor_compensation_top
// Pipelined temperature, pressure and humidity compensation of raw samples.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while no result is held; the divider sets the depth.
// A held result stalls the whole pipeline in place; nothing is lost.
// Reset clears the calibration registers and all valid bits; no clear pass.
`default_nettype none

module env_sensor_compensation_top
  import esc_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // calibration write port
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [63:0]  cfg_data_i,
  // sample in
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [55:0]  s_axis_tdata,   // raw_pressure, raw_temperature, raw_humidity
  // result out
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [119:0] m_axis_tdata,   // temperature_centi, fine_temperature,
                                            // pressure_q24_8, humidity_q22_10, zero pad
  output logic              m_axis_tuser    // pressure_invalid
);

  // Stage counts of each section; the sum sets where results leave.
  localparam int unsigned TfLat   = 4;
  localparam int unsigned NumLat  = 6;
  localparam int unsigned DivLat  = 66;
  localparam int unsigned FinLat  = 5;
  localparam int unsigned HumLat  = 10;
  localparam int unsigned PipeLat = TfLat + NumLat + DivLat + FinLat;

  // Calibration registers
  logic [47:0] temp_q, mixed_q;
  logic [63:0] plow_q, phigh_q;
  logic [31:0] hum_q;
  esc_coef_t   coef;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q  <= '0;
      plow_q  <= '0;
      phigh_q <= '0;
      mixed_q <= '0;
      hum_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegTempCoeffs:     temp_q  <= cfg_data_i[47:0];
        RegPressCoeffsLow: plow_q  <= cfg_data_i;
        RegPressCoeffsHi:  phigh_q <= cfg_data_i;
        RegMixedCoeffs:    mixed_q <= cfg_data_i[47:0];
        RegHumCoeffs:      hum_q   <= cfg_data_i[31:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign coef.t1 = temp_q[15:0];
  assign coef.t2 = temp_q[31:16];
  assign coef.t3 = temp_q[47:32];
  assign coef.p1 = plow_q[15:0];
  assign coef.p2 = plow_q[31:16];
  assign coef.p3 = plow_q[47:32];
  assign coef.p4 = plow_q[63:48];
  assign coef.p5 = phigh_q[15:0];
  assign coef.p6 = phigh_q[31:16];
  assign coef.p7 = phigh_q[47:32];
  assign coef.p8 = phigh_q[63:48];
  assign coef.p9 = mixed_q[15:0];
  assign coef.h1 = mixed_q[23:16];
  assign coef.h2 = mixed_q[39:24];
  assign coef.h3 = mixed_q[47:40];
  assign coef.h4 = hum_q[11:0];
  assign coef.h5 = hum_q[23:12];
  assign coef.h6 = hum_q[31:24];

  // Advance every stage together unless a finished result is held.
  logic en;
  logic out_valid_q;
  logic [PipeLat-1:0] vld_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[PipeLat-2:0], s_axis_tvalid};
      out_valid_q <= vld_q[PipeLat-1];
    end
  end

  // Unpack the request
  logic [19:0] raw_p, raw_t;
  logic [15:0] raw_h;
  assign raw_p = s_axis_tdata[19:0];
  assign raw_t = s_axis_tdata[39:20];
  assign raw_h = s_axis_tdata[55:40];

  // Temperature
  logic signed [31:0] tf, tc;
  esc_temp u_temp (
    .clk_i   (clk_i),
    .en_i    (en),
    .coef_i  (coef),
    .raw_t_i (raw_t),
    .tf_o    (tf),
    .tc_o    (tc)
  );

  // Hold pressure and humidity codes until fine temperature is ready.
  logic [19:0] raw_p_dly;
  logic [15:0] raw_h_dly;
  esc_delay #(.Width(20), .Depth(TfLat)) u_dly_p (
    .clk_i (clk_i), .en_i (en), .d_i (raw_p), .q_o (raw_p_dly)
  );
  esc_delay #(.Width(16), .Depth(TfLat)) u_dly_h (
    .clk_i (clk_i), .en_i (en), .d_i (raw_h), .q_o (raw_h_dly)
  );

  // Pressure: dividend and divisor, divide, then correction terms
  logic signed [63:0] num, den, quo;
  logic               div_zero;
  logic        [31:0] press;

  esc_press_num u_num (
    .clk_i   (clk_i),
    .en_i    (en),
    .coef_i  (coef),
    .tf_i    (tf),
    .raw_p_i (raw_p_dly),
    .num_o   (num),
    .den_o   (den)
  );

  esc_div u_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (num),
    .den_i  (den),
    .quo_o  (quo),
    .zero_o (div_zero)
  );

  esc_press_fin u_fin (
    .clk_i   (clk_i),
    .en_i    (en),
    .coef_i  (coef),
    .p_i     (quo),
    .press_o (press)
  );

  // Humidity
  logic [16:0] hum;
  esc_hum u_hum (
    .clk_i   (clk_i),
    .en_i    (en),
    .coef_i  (coef),
    .tf_i    (tf),
    .raw_h_i (raw_h_dly),
    .hum_o   (hum)
  );

  // Align the short paths with the pressure result.
  logic [31:0] tc_al, tf_al;
  logic [16:0] hum_al;
  logic        zero_al;
  esc_delay #(.Width(32), .Depth(PipeLat - TfLat - 1)) u_dly_tc (
    .clk_i (clk_i), .en_i (en), .d_i (tc), .q_o (tc_al)
  );
  esc_delay #(.Width(32), .Depth(PipeLat - TfLat)) u_dly_tf (
    .clk_i (clk_i), .en_i (en), .d_i (tf), .q_o (tf_al)
  );
  esc_delay #(.Width(17), .Depth(PipeLat - TfLat - HumLat)) u_dly_hum (
    .clk_i (clk_i), .en_i (en), .d_i (hum), .q_o (hum_al)
  );
  esc_delay #(.Width(1), .Depth(FinLat)) u_dly_zero (
    .clk_i (clk_i), .en_i (en), .d_i (div_zero), .q_o (zero_al)
  );

  // Output register; force pressure to zero on a zero divisor.
  logic [31:0] tc_q, tf_q, press_q;
  logic [16:0] hum_out_q;
  logic        inval_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      tc_q      <= tc_al;
      tf_q      <= tf_al;
      press_q   <= zero_al ? '0 : press;
      inval_q   <= zero_al;
      hum_out_q <= hum_al;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, hum_out_q, press_q, tf_q, tc_q};
  assign m_axis_tuser  = inval_q;

endmodule

`default_nettype wire

// File: sv/esc_delay.sv
// ----------------------------------------------------------------------------
// esc_delay
// Enabled shift line that aligns side data with the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_delay #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [Width-1:0] d_i,
  output logic      [Width-1:0] q_o
);

  logic [Width-1:0] tap_q [Depth];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < Depth; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[Depth-1];

endmodule

`default_nettype wire

// File: sv/esc_mull64.sv
// ----------------------------------------------------------------------------
// esc_mull64
// Two-stage multiplier returning the low 64 bits of a 64 by 64 product.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_mull64 (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic      [63:0] p_o
);

  logic [63:0] pp0_q;
  logic [31:0] pp1_q, pp2_q;
  logic [63:0] pp0_d, pp1_full, pp2_full;
  logic [63:0] p_q;

  assign pp0_d    = a_i[31:0] * b_i[31:0];
  assign pp1_full = a_i[31:0] * b_i[63:32];
  assign pp2_full = a_i[63:32] * b_i[31:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp0_q <= pp0_d;
      pp1_q <= pp1_full[31:0];
      pp2_q <= pp2_full[31:0];
      p_q   <= pp0_q + {pp1_q + pp2_q, 32'd0};
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// File: sv/esc_temp.sv
// ----------------------------------------------------------------------------
// esc_temp
// Fine temperature (4 stages) and centidegree temperature (5 stages).
// ----------------------------------------------------------------------------
`default_nettype none

module esc_temp
  import esc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire esc_coef_t          coef_i,
  input  wire logic        [19:0] raw_t_i,
  output logic signed      [31:0] tf_o,
  output logic signed      [31:0] tc_o
);

  logic signed [17:0] a_d, a_q;
  logic signed [16:0] d_d, d_q;
  logic signed [33:0] pa_d, pa_q, dd_d, dd_q;
  logic signed [31:0] v1_d, v1_q, s_d, s_q;
  logic signed [47:0] m3;
  logic signed [31:0] tf_d, tf_q, tc_d, tc_q;
  logic        [31:0] t5;

  assign a_d  = $signed({1'b0, raw_t_i[19:3]}) - $signed({1'b0, coef_i.t1, 1'b0});
  assign d_d  = $signed({1'b0, raw_t_i[19:4]}) - $signed({1'b0, coef_i.t1});
  assign pa_d = a_q * $signed(coef_i.t2);
  assign dd_d = d_q * d_q;
  assign v1_d = $signed(pa_q[31:0]) >>> 11;
  assign s_d  = $signed(dd_q[31:0]) >>> 12;
  assign m3   = s_q * $signed(coef_i.t3);
  assign tf_d = v1_q + ($signed(m3[31:0]) >>> 14);
  assign t5   = tf_q * 32'd5 + 32'd128;
  assign tc_d = $signed(t5) >>> 8;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q  <= a_d;
      d_q  <= d_d;
      pa_q <= pa_d;
      dd_q <= dd_d;
      v1_q <= v1_d;
      s_q  <= s_d;
      tf_q <= tf_d;
      tc_q <= tc_d;
    end
  end

  assign tf_o = tf_q;
  assign tc_o = tc_q;

endmodule

`default_nettype wire

// File: sv/esc_press_num.sv
// ----------------------------------------------------------------------------
// esc_press_num
// Pressure dividend and divisor from fine temperature, six stages.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_press_num
  import esc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire esc_coef_t          coef_i,
  input  wire logic signed [31:0] tf_i,
  input  wire logic        [19:0] raw_p_i,
  output logic signed      [63:0] num_o,
  output logic signed      [63:0] den_o
);

  logic signed [32:0] w1_q;
  logic        [19:0] rp_q [4];
  logic signed [65:0] sq_full;
  logic signed [48:0] m5_full, m2_full;
  logic signed [63:0] sq_q, m5_q, m2_q, m5b_q, m2b_q;
  logic signed [79:0] x6_full, x3_full;
  logic signed [63:0] x6_q, x3_q;
  logic signed [63:0] w2_d, w2_q, w1b_d, w1b_q;
  logic signed [63:0] p4_sh;
  logic        [20:0] pr;
  logic signed [63:0] n1_d, n1_q, t_d, t_q;
  logic signed [80:0] q_full;
  logic signed [76:0] num_full;
  logic signed [63:0] den_q, num_q;

  assign sq_full  = w1_q * w1_q;
  assign m5_full  = w1_q * $signed(coef_i.p5);
  assign m2_full  = w1_q * $signed(coef_i.p2);
  assign x6_full  = sq_q * $signed(coef_i.p6);
  assign x3_full  = sq_q * $signed(coef_i.p3);
  assign p4_sh    = {{13{coef_i.p4[15]}}, coef_i.p4, 35'd0};
  assign w2_d     = x6_q + (m5b_q <<< 17) + p4_sh;
  assign w1b_d    = (x3_q >>> 8) + (m2b_q <<< 12);
  assign pr       = PressFull - {1'b0, rp_q[3]};
  assign n1_d     = $signed({12'd0, pr, 31'd0}) - w2_q;
  assign t_d      = $signed(64'd1 << 47) + w1b_q;
  assign q_full   = t_q * $signed({1'b0, coef_i.p1});
  assign num_full = n1_q * PressScale;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w1_q  <= 33'(tf_i) - TempOffset;
      rp_q[0] <= raw_p_i;
      for (int i = 1; i < 4; i++) begin
        rp_q[i] <= rp_q[i-1];
      end
      sq_q  <= sq_full[63:0];
      m5_q  <= 64'(m5_full);
      m2_q  <= 64'(m2_full);
      x6_q  <= x6_full[63:0];
      x3_q  <= x3_full[63:0];
      m5b_q <= m5_q;
      m2b_q <= m2_q;
      w2_q  <= w2_d;
      w1b_q <= w1b_d;
      n1_q  <= n1_d;
      t_q   <= t_d;
      den_q <= $signed(q_full[63:0]) >>> 33;
      num_q <= num_full[63:0];
    end
  end

  assign num_o = num_q;
  assign den_o = den_q;

endmodule

`default_nettype wire

// File: sv/esc_div.sv
// ----------------------------------------------------------------------------
// esc_div
// Pipelined signed 64-bit divider, truncating, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_div (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [63:0] num_i,
  input  wire logic signed [63:0] den_i,
  output logic signed      [63:0] quo_o,
  output logic                    zero_o
);

  localparam int unsigned Steps = 64;

  logic [63:0] rem_q [Steps+1];
  logic [63:0] dd_q  [Steps+1];
  logic [63:0] ub_q  [Steps+1];
  logic        neg_q [Steps+1];
  logic        zero_q[Steps+1];
  logic signed [63:0] quo_q;
  logic        zero_out_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= '0;
      dd_q[0]   <= num_i[63] ? 64'(-num_i) : num_i;
      ub_q[0]   <= den_i[63] ? 64'(-den_i) : den_i;
      neg_q[0]  <= num_i[63] ^ den_i[63];
      zero_q[0] <= (den_i == '0);
      quo_q      <= neg_q[Steps] ? $signed(-dd_q[Steps]) : $signed(dd_q[Steps]);
      zero_out_q <= zero_q[Steps];
    end
  end

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [64:0] r_sh, diff;
    logic        ge;
    assign r_sh = {rem_q[s], dd_q[s][63]};
    assign diff = r_sh - {1'b0, ub_q[s]};
    assign ge   = (r_sh >= {1'b0, ub_q[s]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= ge ? diff[63:0] : r_sh[63:0];
        dd_q[s+1]   <= {dd_q[s][62:0], ge};
        ub_q[s+1]   <= ub_q[s];
        neg_q[s+1]  <= neg_q[s];
        zero_q[s+1] <= zero_q[s];
      end
    end
  end

  assign quo_o  = quo_q;
  assign zero_o = zero_out_q;

endmodule

`default_nettype wire

// File: sv/esc_press_fin.sv
// ----------------------------------------------------------------------------
// esc_press_fin
// Pressure correction terms and Q24.8 result, five stages.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_press_fin
  import esc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire esc_coef_t          coef_i,
  input  wire logic signed [63:0] p_i,
  output logic             [31:0] press_o
);

  logic signed [63:0] ps;
  logic signed [79:0] a9_full, e2_full;
  logic signed [63:0] a9_q, ps_q, e2_q [3], p_q [3];
  logic        [63:0] prod;
  logic signed [63:0] sum_d, sum_q;
  logic        [31:0] p7_sh, press_q;

  assign ps      = p_i >>> 13;
  assign a9_full = ps * $signed(coef_i.p9);
  assign e2_full = p_i * $signed(coef_i.p8);

  esc_mull64 u_mull (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (a9_q),
    .b_i   (ps_q),
    .p_o   (prod)
  );

  assign sum_d = p_q[2] + ($signed(prod) >>> 25) + (e2_q[2] >>> 19);
  assign p7_sh = {{12{coef_i.p7[15]}}, coef_i.p7, 4'd0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a9_q    <= a9_full[63:0];
      ps_q    <= ps;
      e2_q[0] <= e2_full[63:0];
      p_q[0]  <= p_i;
      for (int i = 1; i < 3; i++) begin
        e2_q[i] <= e2_q[i-1];
        p_q[i]  <= p_q[i-1];
      end
      sum_q   <= sum_d;
      press_q <= sum_q[39:8] + p7_sh;
    end
  end

  assign press_o = press_q;

endmodule

`default_nettype wire

// File: sv/esc_hum.sv
// ----------------------------------------------------------------------------
// esc_hum
// Relative humidity in Q22.10, clamped, ten stages.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_hum
  import esc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire esc_coef_t          coef_i,
  input  wire logic signed [31:0] tf_i,
  input  wire logic        [15:0] raw_h_i,
  output logic             [16:0] hum_o
);

  logic signed [31:0] hv_q, m5_q, m6_q, m3_q, x_q [4], ya_q, yb_q;
  logic        [15:0] rh_q [2];
  logic signed [43:0] m5_full;
  logic signed [39:0] m6_full;
  logic signed [40:0] m3_full, t_full;
  logic signed [31:0] xs, y1_q, y2, y3p_q, y_q, hv2_q [3], s, sq_q, t_q, h3v;
  logic signed [63:0] y1_full, hv2_full, sq_full;
  logic signed [47:0] y3_full;
  logic        [16:0] hum_d, hum_q;

  assign m5_full  = hv_q * $signed(coef_i.h5);
  assign m6_full  = hv_q * $signed(coef_i.h6);
  assign m3_full  = hv_q * $signed({1'b0, coef_i.h3});
  assign xs       = $signed({2'd0, rh_q[1], 14'd0}) - $signed({coef_i.h4, 20'd0})
                    - m5_q + HumRound;
  assign y1_full  = ya_q * yb_q;
  assign y2       = ($signed(y1_q) >>> 10) + HumBias;
  assign y3_full  = y2 * $signed(coef_i.h2);
  assign hv2_full = x_q[3] * y_q;
  assign s        = hv2_q[0] >>> 15;
  assign sq_full  = s * s;
  assign t_full   = ($signed(sq_q) >>> 7) * $signed({1'b0, coef_i.h1});
  assign h3v      = hv2_q[2] - (t_q >>> 4);

  always_comb begin
    if (h3v[31]) begin
      hum_d = '0;
    end else if (h3v > HumMax) begin
      hum_d = HumMax[28:12];
    end else begin
      hum_d = h3v[28:12];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hv_q    <= tf_i - HumTempOfs;
      rh_q[0] <= raw_h_i;
      rh_q[1] <= rh_q[0];
      m5_q    <= m5_full[31:0];
      m6_q    <= m6_full[31:0];
      m3_q    <= m3_full[31:0];
      x_q[0]  <= xs >>> 15;
      ya_q    <= m6_q >>> 10;
      yb_q    <= (m3_q >>> 11) + HumHalf;
      for (int i = 1; i < 4; i++) begin
        x_q[i] <= x_q[i-1];
      end
      y1_q     <= y1_full[31:0];
      y3p_q    <= y3_full[31:0];
      y_q      <= (y3p_q + HumRoundY) >>> 14;
      hv2_q[0] <= hv2_full[31:0];
      hv2_q[1] <= hv2_q[0];
      hv2_q[2] <= hv2_q[1];
      sq_q     <= sq_full[31:0];
      t_q      <= t_full[31:0];
      hum_q    <= hum_d;
    end
  end

  assign hum_o = hum_q;

endmodule

`default_nettype wire
